// ===== rtl/core/lwu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwu_pkg
// Shared sizes, selector codes and register indexes of the worm update block.
// ----------------------------------------------------------------------------
package lwu_pkg;

	localparam int MAX_SITES      = 4096;
	localparam int MAX_DIM        = 3;
	localparam int MAX_COLORS     = 3;
	localparam int MAX_LINK_BONDS = 15;

	localparam int SITE_W       = $clog2(MAX_SITES);
	localparam int LINK_DEPTH   = 2 * MAX_DIM * MAX_SITES;
	localparam int CHG_DEPTH    = 2 * MAX_DIM * MAX_COLORS * MAX_SITES;
	localparam int LINK_AW      = $clog2(LINK_DEPTH);
	localparam int CHG_AW       = $clog2(CHG_DEPTH);
	localparam int WIND_DEPTH   = MAX_DIM * MAX_COLORS;
	localparam int WIND_AW      = $clog2(WIND_DEPTH);
	localparam int WEIGHT_DEPTH = MAX_LINK_BONDS + 1;
	localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);

	typedef enum logic [2:0] {
		FN_STEP   = 3'd0,
		FN_NBR    = 3'd1,
		FN_WEIGHT = 3'd2,
		FN_CREATE = 3'd3,
		FN_READ   = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		CFG_DIM      = 3'd0,
		CFG_COLORS   = 3'd1,
		CFG_SITES    = 3'd2,
		CFG_LIMIT    = 3'd3,
		CFG_RELOCATE = 3'd4,
		CFG_REPAINT  = 3'd5,
		CFG_PAIR     = 3'd6
	} cfg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/lwu_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lwu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lwu_mod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwu_mod
// Bit-serial restoring remainder unit: site draw modulo the site count.
// ----------------------------------------------------------------------------
module lwu_mod import lwu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SITE_W-1:0] dividend,
	input  wire logic [SITE_W:0]   divisor,
	output logic                   done,
	output logic      [SITE_W-1:0] rem
);

	logic                      busy_q;
	logic                      done_q;
	logic [$clog2(SITE_W)-1:0] cnt_q;
	logic [SITE_W-1:0]         rem_q;
	logic [SITE_W-1:0]         sh_q;
	logic [SITE_W:0]           div_q;
	logic [SITE_W:0]           trial;
	logic [SITE_W:0]           next_rem;

	always_comb begin
		trial    = {rem_q, sh_q[SITE_W-1]};
		next_rem = (trial >= div_q) ? trial - div_q : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(SITE_W))'(SITE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the site width
			rem_q <= next_rem[SITE_W-1:0];
			sh_q  <= {sh_q[SITE_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/lattice_worm_update_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lattice_worm_update_top
// Worm-algorithm Monte Carlo step over charge, link-count and neighbor RAMs.
// ----------------------------------------------------------------------------
// Sequence after the accepting edge: loads, reads and unused selectors go
//   to ST_OUT; a step runs ST_ADDR, ST_R0, ST_R1, ST_R2 and, if accepted,
//   ST_W1 to ST_W4 before ST_OUT; relocation first waits in ST_DIV.
// Throughput: one transaction at a time; in_ready rises with out_valid.
// Reset: after arst_n the block sweeps the charge and link-count RAMs to zero,
//   one entry per cycle, with in_ready low; config writes are taken meanwhile.
module lattice_worm_update_top import lwu_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [32:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         func,
	input  wire logic [14:0]        table_index,
	input  wire logic [32:0]        table_value,
	input  wire logic [31:0]        rand_relocate,
	input  wire logic [11:0]        rand_site,
	input  wire logic [31:0]        rand_repaint,
	input  wire logic [1:0]         rand_forward_color,
	input  wire logic               rand_color_offset,
	input  wire logic [2:0]         rand_direction,
	input  wire logic [31:0]        rand_accept,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [11:0]        head_site,
	output logic      [11:0]        tail_site,
	output logic      [1:0]         forward_color,
	output logic      [1:0]         backward_color,
	output logic                    moved,
	output logic                    loop_closed,
	output logic signed [31:0]      total_bonds,
	output logic signed [31:0]      read_value
);

	typedef enum logic [12:0] {
		ST_CLEAR = 13'b0000000000001,
		ST_IDLE  = 13'b0000000000010,
		ST_DIV   = 13'b0000000000100,
		ST_ADDR  = 13'b0000000001000,
		ST_R0    = 13'b0000000010000,
		ST_R1    = 13'b0000000100000,
		ST_R2    = 13'b0000001000000,
		ST_W1    = 13'b0000010000000,
		ST_W2    = 13'b0000100000000,
		ST_W3    = 13'b0001000000000,
		ST_W4    = 13'b0010000000000,
		ST_OUT   = 13'b0100000000000,
		ST_SPARE = 13'b1000000000000
	} state_t;

	// small operand modulo colour count (2 or 3); v never exceeds 4
	function automatic logic [1:0] mod_col(input logic [2:0] v, input logic [1:0] c);
		logic [2:0] r;
		r = (c == 2'd3) ? ((v >= 3'd3) ? v - 3'd3 : v) : {2'b00, v[0]};
		return r[1:0];
	endfunction

	state_t state_q;

	// configuration
	logic [1:0]          dim_q;
	logic [1:0]          col_q;
	logic [12:0]         sites_q;
	logic [3:0]          limit_q;
	logic [32:0]         reloc_q;
	logic [32:0]         repaint_q;
	logic                pair_q;

	// worm state
	logic [SITE_W-1:0]   head_q;
	logic [SITE_W-1:0]   tail_q;
	logic [1:0]          fwd_q;
	logic [1:0]          bwd_q;
	logic [31:0]         total_q;
	logic [31:0]         wind_q [WIND_DEPTH];
	logic [32:0]         weight_q [WEIGHT_DEPTH];

	// captured transaction
	logic [2:0]          func_q;
	logic [2:0]          rdir_q;
	logic [31:0]         racc_q;

	// step working registers
	logic [2:0]          dir_q;
	logic [2:0]          dir2_q;
	logic [1:0]          axis_q;
	logic                up_q;
	logic [1:0]          fc_q;
	logic [1:0]          bc_q;
	logic [LINK_AW-1:0]  l1_q;
	logic [LINK_AW-1:0]  l2_q;
	logic [CHG_AW-1:0]   b1_q;
	logic [CHG_AW-1:0]   b2_q;
	logic [7:0]          f_q;
	logic [7:0]          b_q;
	logic [7:0]          cnt_q;
	logic [7:0]          c2f_q;
	logic [7:0]          c2b_q;
	logic [7:0]          lnk2_q;
	logic [SITE_W-1:0]   n_q;
	logic [1:0]          bd_q;
	logic [CHG_AW-1:0]   clr_q;

	// result staging
	logic                moved_q;
	logic [31:0]         readv_q;
	logic                out_valid_q;
	logic [11:0]         o_head_q;
	logic [11:0]         o_tail_q;
	logic [1:0]          o_fwd_q;
	logic [1:0]          o_bwd_q;
	logic                o_moved_q;
	logic                o_closed_q;
	logic [31:0]         o_total_q;
	logic [31:0]         o_readv_q;

	// effective configuration
	logic [1:0]          eff_dim;
	logic [1:0]          eff_col;
	logic [12:0]         eff_sites;
	logic [2:0]          two_d;

	logic                accept;
	logic                closed;
	logic                do_reloc;
	logic                do_repaint;
	logic [1:0]          new_fwd;
	logic [1:0]          new_bwd;
	logic [2:0]          bwd_sum;

	logic                div_start;
	logic                div_done;
	logic [SITE_W-1:0]   div_rem;

	logic [2:0]          dir_c;
	logic [2:0]          dir2_c;
	logic [1:0]          axis_c;
	logic [4:0]          cdir2_c;
	logic [4:0]          two_cd;

	logic [1:0]          bd_c;
	logic signed [9:0]   cnt_sum;
	logic                acc_c;

	// RAM ports
	logic                chg_we;
	logic [CHG_AW-1:0]   chg_waddr;
	logic [7:0]          chg_wdata;
	logic                chg_re;
	logic [CHG_AW-1:0]   chg_raddr;
	logic [7:0]          chg_rdata;
	logic                lnk_we;
	logic [LINK_AW-1:0]  lnk_waddr;
	logic [7:0]          lnk_wdata;
	logic                lnk_re;
	logic [7:0]          lnk_rdata;
	logic                nbr_we;
	logic                nbr_re;
	logic [SITE_W-1:0]   nbr_rdata;

	logic [WIND_AW:0]    wi_a;
	logic [WIND_AW:0]    wi_b;
	logic                we_a;
	logic                we_b;
	logic [31:0]         wd_a;
	logic [31:0]         wd_b;

	always_comb begin
		eff_dim   = (dim_q == 2'd0) ? 2'd1 : dim_q;
		eff_col   = (col_q < 2'd2) ? 2'd2 : col_q;
		eff_sites = (sites_q == 13'd0) ? 13'd1 :
		            ((sites_q > 13'(MAX_SITES)) ? 13'(MAX_SITES) : sites_q);
		two_d     = {eff_dim, 1'b0};
		two_cd    = 5'(two_d * eff_col);
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		closed     = (head_q == tail_q);
		do_reloc   = (func == FN_CREATE) ||
		             ((func == FN_STEP) && closed && (reloc_q > {1'b0, rand_relocate}));
		do_repaint = (func == FN_CREATE) ||
		             ((func == FN_STEP) && closed && (repaint_q > {1'b0, rand_repaint}));
		new_fwd    = mod_col({1'b0, rand_forward_color}, eff_col);
		bwd_sum    = {1'b0, new_fwd} + ((eff_col == 2'd3) ? {2'b00, rand_color_offset} : 3'd0)
		             + 3'd1;
		new_bwd    = mod_col(bwd_sum, eff_col);
		div_start  = accept && do_reloc;
	end

	lwu_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rand_site),
		.divisor  (eff_sites),
		.done     (div_done),
		.rem      (div_rem)
	);

	// direction decode for the current head
	always_comb begin
		unique case (eff_dim)
			2'd1:    dir_c = {2'b00, rdir_q[0]};
			2'd2:    dir_c = {1'b0, rdir_q[1:0]};
			default: dir_c = (rdir_q >= 3'd6) ? rdir_q - 3'd6 : rdir_q;
		endcase
		dir2_c  = (dir_c < {1'b0, eff_dim}) ? dir_c + {1'b0, eff_dim} : dir_c - {1'b0, eff_dim};
		axis_c  = (dir_c < {1'b0, eff_dim}) ? dir_c[1:0] : 2'(dir_c - {1'b0, eff_dim});
		cdir2_c = 5'(dir2_q * eff_col);
	end

	// bond change from charge signs, then the acceptance test
	always_comb begin
		if (!f_q[7] && ($signed(chg_rdata) <= 0)) begin
			bd_c = 2'b01;
		end else if (f_q[7] && ($signed(chg_rdata) > 0)) begin
			bd_c = 2'b11;
		end else begin
			bd_c = 2'b00;
		end
		cnt_sum = $signed({2'b00, cnt_q}) + 10'(signed'(bd_c));
		acc_c   = (cnt_sum <= $signed({6'd0, limit_q})) &&
		          ((bd_c != 2'b01) || (weight_q[cnt_q[WEIGHT_AW-1:0]] > {1'b0, racc_q}));
	end

	// RAM port steering
	always_comb begin
		chg_we    = 1'b0;
		chg_waddr = b1_q + CHG_AW'(fc_q);
		chg_wdata = f_q + 8'd1;
		chg_re    = 1'b0;
		chg_raddr = b1_q + CHG_AW'(fc_q);
		lnk_we    = 1'b0;
		lnk_waddr = l1_q;
		lnk_wdata = cnt_q + {{6{bd_q[1]}}, bd_q};
		lnk_re    = 1'b0;
		nbr_we    = accept && (func == FN_NBR) && (table_index < 15'(LINK_DEPTH));
		nbr_re    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				chg_we    = 1'b1;
				chg_waddr = clr_q;
				chg_wdata = 8'd0;
				lnk_we    = (clr_q < CHG_AW'(LINK_DEPTH));
				lnk_waddr = clr_q[LINK_AW-1:0];
				lnk_wdata = 8'd0;
			end
			ST_R0: begin
				chg_re = 1'b1;
				lnk_re = 1'b1;
				nbr_re = 1'b1;
			end
			ST_R1: begin
				chg_re    = 1'b1;
				chg_raddr = b1_q + CHG_AW'(bc_q);
			end
			ST_W1: begin
				// equal colours: +1 and -1 on one entry cancel, so skip the charge writes
				chg_we    = (fc_q != bc_q);
				lnk_we    = 1'b1;
				chg_re    = 1'b1;
				chg_raddr = b2_q + CHG_AW'(fc_q);
				lnk_re    = 1'b1;
			end
			ST_W2: begin
				chg_we    = (fc_q != bc_q);
				chg_waddr = b1_q + CHG_AW'(bc_q);
				chg_wdata = b_q - 8'd1;
				chg_re    = 1'b1;
				chg_raddr = b2_q + CHG_AW'(bc_q);
			end
			ST_W3: begin
				chg_we    = (fc_q != bc_q);
				chg_waddr = b2_q + CHG_AW'(fc_q);
				chg_wdata = c2f_q - 8'd1;
				lnk_we    = 1'b1;
				lnk_waddr = l2_q;
				lnk_wdata = lnk2_q + {{6{bd_q[1]}}, bd_q};
			end
			ST_W4: begin
				chg_we    = (fc_q != bc_q);
				chg_waddr = b2_q + CHG_AW'(bc_q);
				chg_wdata = c2b_q + 8'd1;
			end
			default: begin
			end
		endcase
	end

	lwu_ram #(.WIDTH(8), .DEPTH(CHG_DEPTH)) u_chg_ram (
		.clk   (clk),
		.we    (chg_we),
		.waddr (chg_waddr),
		.wdata (chg_wdata),
		.re    (chg_re),
		.raddr (chg_raddr),
		.rdata (chg_rdata)
	);

	lwu_ram #(.WIDTH(8), .DEPTH(LINK_DEPTH)) u_lnk_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.re    (lnk_re),
		.raddr ((state_q == ST_W1) ? l2_q : l1_q),
		.rdata (lnk_rdata)
	);

	lwu_ram #(.WIDTH(SITE_W), .DEPTH(LINK_DEPTH)) u_nbr_ram (
		.clk   (clk),
		.we    (nbr_we),
		.waddr (table_index[LINK_AW-1:0]),
		.wdata (table_value[SITE_W-1:0]),
		.re    (nbr_re),
		.raddr (l1_q),
		.rdata (nbr_rdata)
	);

	// winding counter targets for an accepted move
	always_comb begin
		wi_a = (WIND_AW+1)'(eff_col * axis_q) + (WIND_AW+1)'(fc_q);
		wi_b = (WIND_AW+1)'(eff_col * axis_q) + (WIND_AW+1)'(bc_q);
		if (!pair_q) begin
			we_a = (fc_q != bc_q);
			we_b = (fc_q != bc_q);
			wd_a = up_q ? 32'd1 : 32'hFFFF_FFFF;
			wd_b = up_q ? 32'hFFFF_FFFF : 32'd1;
		end else begin
			wi_a = (WIND_AW+1)'(eff_col * axis_q) + (WIND_AW+1)'(fc_q)
			       + (WIND_AW+1)'(bc_q) - 1'b1;
			we_a = (fc_q != bc_q);
			we_b = 1'b0;
			wd_a = (up_q == (fc_q > bc_q)) ? 32'd1 : 32'hFFFF_FFFF;
			wd_b = 32'd0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			dim_q       <= 2'd2;
			col_q       <= 2'd3;
			sites_q     <= 13'(MAX_SITES);
			limit_q     <= 4'(MAX_LINK_BONDS);
			reloc_q     <= '0;
			repaint_q   <= '0;
			pair_q      <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			fwd_q       <= 2'd0;
			bwd_q       <= 2'd1;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WIND_DEPTH; i++) begin
				wind_q[i] <= '0;
			end
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_DIM:      dim_q     <= cfg_data[1:0];
					CFG_COLORS:   col_q     <= cfg_data[1:0];
					CFG_SITES:    sites_q   <= cfg_data[12:0];
					CFG_LIMIT:    limit_q   <= cfg_data[3:0];
					CFG_RELOCATE: reloc_q   <= cfg_data;
					CFG_REPAINT:  repaint_q <= cfg_data;
					CFG_PAIR:     pair_q    <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CHG_AW'(CHG_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (do_repaint) begin
							fwd_q <= new_fwd;
							bwd_q <= new_bwd;
						end
						if (do_reloc) begin
							state_q <= ST_DIV;
						end else if (func == FN_STEP) begin
							state_q <= ST_ADDR;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						head_q  <= div_rem;
						tail_q  <= div_rem;
						state_q <= (func_q == FN_STEP) ? ST_ADDR : ST_OUT;
					end
				end
				ST_ADDR: state_q <= ST_R0;
				ST_R0:   state_q <= ST_R1;
				ST_R1:   state_q <= ST_R2;
				ST_R2:   state_q <= acc_c ? ST_W1 : ST_OUT;
				ST_W1:   state_q <= ST_W2;
				ST_W2:   state_q <= ST_W3;
				ST_W3:   state_q <= ST_W4;
				ST_W4: begin
					total_q <= total_q + {{30{bd_q[1]}}, bd_q};
					head_q  <= n_q;
					for (int i = 0; i < WIND_DEPTH; i++) begin
						wind_q[i] <= wind_q[i]
						             + ((we_a && (wi_a == (WIND_AW+1)'(i))) ? wd_a : 32'd0)
						             + ((we_b && (wi_b == (WIND_AW+1)'(i))) ? wd_b : 32'd0);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			rdir_q  <= rand_direction;
			racc_q  <= rand_accept;
			moved_q <= 1'b0;
			readv_q <= ((func == FN_READ) && (table_index < 15'(WIND_DEPTH))) ?
			           wind_q[table_index[WIND_AW-1:0]] : 32'd0;
			if ((func == FN_WEIGHT) && (table_index < 15'(WEIGHT_DEPTH))) begin
				weight_q[table_index[WEIGHT_AW-1:0]] <= table_value;
			end
		end
		if (state_q == ST_ADDR) begin
			dir_q  <= dir_c;
			dir2_q <= dir2_c;
			axis_q <= axis_c;
			up_q   <= (dir_c >= {1'b0, eff_dim});
			fc_q   <= mod_col({1'b0, fwd_q}, eff_col);
			bc_q   <= mod_col({1'b0, bwd_q}, eff_col);
			l1_q   <= LINK_AW'(head_q * two_d) + LINK_AW'(dir_c);
			b1_q   <= CHG_AW'(head_q * two_cd) + CHG_AW'(dir_c * eff_col);
		end
		if (state_q == ST_R1) begin
			f_q   <= chg_rdata;
			cnt_q <= lnk_rdata;
			n_q   <= nbr_rdata;
		end
		if (state_q == ST_R2) begin
			b_q  <= chg_rdata;
			bd_q <= bd_c;
			l2_q <= LINK_AW'(n_q * two_d) + LINK_AW'(dir2_q);
			b2_q <= CHG_AW'(n_q * two_cd) + CHG_AW'(cdir2_c);
		end
		if (state_q == ST_W2) begin
			c2f_q  <= chg_rdata;
			lnk2_q <= lnk_rdata;
		end
		if (state_q == ST_W3) begin
			c2b_q <= chg_rdata;
		end
		if (state_q == ST_W4) begin
			moved_q <= 1'b1;
		end
		if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
			o_head_q   <= head_q;
			o_tail_q   <= tail_q;
			o_fwd_q    <= fwd_q;
			o_bwd_q    <= bwd_q;
			o_moved_q  <= moved_q;
			o_closed_q <= (head_q == tail_q);
			o_total_q  <= total_q;
			o_readv_q  <= readv_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign head_site      = o_head_q;
	assign tail_site      = o_tail_q;
	assign forward_color  = o_fwd_q;
	assign backward_color = o_bwd_q;
	assign moved          = o_moved_q;
	assign loop_closed    = o_closed_q;
	assign total_bonds    = signed'(o_total_q);
	assign read_value     = signed'(o_readv_q);

endmodule

`default_nettype wire
